[src/wps_pkg.sv]
// Package with the result type, result and error codes and the tag constants of the WAV parser.
package wps_pkg;

   localparam logic [1:0] KIND_FRAME  = 2'd0;
   localparam logic [1:0] KIND_FORMAT = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [3:0] ERR_SHORT_HEADER = 4'd0;
   localparam logic [3:0] ERR_NO_RIFF      = 4'd1;
   localparam logic [3:0] ERR_NO_WAVE      = 4'd2;
   localparam logic [3:0] ERR_MISSING      = 4'd3;
   localparam logic [3:0] ERR_FMT_SMALL    = 4'd4;
   localparam logic [3:0] ERR_FMT_CUT      = 4'd5;
   localparam logic [3:0] ERR_NOT_PCM      = 4'd6;
   localparam logic [3:0] ERR_CHANNELS     = 4'd7;
   localparam logic [3:0] ERR_DEPTH        = 4'd8;
   localparam logic [3:0] ERR_ALIGN        = 4'd9;
   localparam logic [3:0] ERR_SAMPLES_CUT  = 4'd10;
   localparam logic [3:0] ERR_DATA_EARLY   = 4'd11;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;
   localparam logic [31:0] FMT_BODY_BYTES = 32'd16;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [15:0] left_sample;
      logic [15:0] right_sample;
      logic [1:0]  channels;
      logic [31:0] sample_rate;
      logic [31:0] byte_rate;
      logic [15:0] block_align;
      logic [31:0] frame_count;
      logic [3:0]  error_code;
      logic        last;
   } result_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
      logic [15:0] remainder;
   } div_rsp_type;

   function automatic result_type error_result(logic [3:0] code);
      result_type r;
      r = '0;
      r.result_kind = KIND_ERROR;
      r.error_code = code;
      r.last = 1'b1;
      return r;
   endfunction

endpackage

[src/wps_divider.sv]
// Restoring divider that produces one quotient bit per cycle for the frame count.
module wps_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  wps_pkg::div_req_type div_req,
   output wps_pkg::div_rsp_type div_rsp
);

   logic [31:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [5:0]  steps_ff, steps_in;
   logic        done_ff, done_in;
   logic [16:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      steps_in = steps_ff;
      done_in = 1'b0;
      trial = {rem_ff[15:0], quot_ff[31]};
      if (div_req.start) begin
         quot_in = div_req.dividend;
         rem_in = '0;
         dsr_in = div_req.divisor;
         steps_in = 6'd32;
      end else if (steps_ff != 6'd0) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quot_in = {quot_ff[30:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[30:0], 1'b0};
         end
         steps_in = steps_ff - 6'd1;
         done_in = (steps_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         steps_ff <= steps_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quot_ff;
   assign div_rsp.remainder = rem_ff[15:0];

endmodule

[src/wav_pcm16_stream_parser.sv]
// Top level of the byte-serial WAV parser for 16-bit PCM mono and stereo streams.
//
//   channel  direction  handshake                  payload
//   req_     in         req_valid / req_stall      data_byte, end_of_file
//   rsp_     out        rsp_valid / rsp_stall      result fields, last
//
// One byte is taken per cycle while the result queue holds at most two requests and no division is running.
// The data chunk header starts the divider, and the input is stalled until the division is done.
// Reset is synchronous and returns the parser to idle with an empty result queue.
// A stalled result stays at the head of a four-entry queue; input stops once it holds three.
module wav_pcm16_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic signed [15:0] rsp_left_sample,
   output logic signed [15:0] rsp_right_sample,
   output logic [1:0]  rsp_channels,
   output logic [31:0] rsp_sample_rate,
   output logic [31:0] rsp_byte_rate,
   output logic [15:0] rsp_block_align,
   output logic [31:0] rsp_frame_count,
   output logic [3:0]  rsp_error_code,
   output logic        rsp_last
);

   localparam logic [3:0] PH_HDR   = 4'd0;
   localparam logic [3:0] PH_CHDR  = 4'd1;
   localparam logic [3:0] PH_FMT   = 4'd2;
   localparam logic [3:0] PH_FSKIP = 4'd3;
   localparam logic [3:0] PH_SKIP  = 4'd4;
   localparam logic [3:0] PH_DATA  = 4'd5;
   localparam logic [3:0] PH_TAIL  = 4'd6;
   localparam logic [3:0] PH_ERR   = 4'd7;
   localparam logic [3:0] PH_DIV   = 4'd8;

   logic [3:0]  phase_ff, phase_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] len_ff, len_in;
   logic [63:0] fmt0_ff, fmt0_in;
   logic [63:0] fmt1_ff, fmt1_in;
   logic        seen_ff, seen_in;
   logic [31:0] frames_ff, frames_in;
   logic [31:0] asm_ff, asm_in;
   logic        riff_ff, riff_in;
   logic [32:0] skip_ff, skip_in;
   logic        eofp_ff, eofp_in;

   wps_pkg::result_type fifo_ff [4];
   logic [2:0]  count_ff, count_in;
   logic [1:0]  head_ff, tail_ff;

   wps_pkg::div_req_type div_req;
   wps_pkg::div_rsp_type div_rsp;

   logic accept, pop, main_v, eof_v, eof_now;
   logic [1:0] n_push;
   wps_pkg::result_type main_r, eof_r, wr0, wr1;

   wps_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (count_ff > 3'd2) || (phase_ff == PH_DIV);
   assign accept = req_valid && !req_stall;
   assign pop = rsp_valid && !rsp_stall;

   always_comb begin
      logic [1:0]  ch2;
      logic [31:0] len_odd;
      phase_in = phase_ff;
      cnt_in = cnt_ff;
      tag_in = tag_ff;
      len_in = len_ff;
      fmt0_in = fmt0_ff;
      fmt1_in = fmt1_ff;
      seen_in = seen_ff;
      frames_in = frames_ff;
      asm_in = asm_ff;
      riff_in = riff_ff;
      skip_in = skip_ff;
      eofp_in = eofp_ff;
      main_v = 1'b0;
      main_r = '0;
      eof_v = 1'b0;
      eof_r = '0;
      eof_now = 1'b0;
      div_req.start = 1'b0;
      div_req.dividend = len_ff;
      div_req.divisor = fmt1_ff[47:32];
      ch2 = fmt0_ff[17:16];
      len_odd = {31'd0, len_ff[0]};

      if (accept) begin
         eof_now = req_end_of_file;
         unique case (phase_ff)
            PH_HDR: begin
               if (cnt_ff < 5'd4) begin
                  tag_in[8*cnt_ff[1:0] +: 8] = tag_ff[8*cnt_ff[1:0] +: 8] | req_data_byte;
                  if (cnt_ff == 5'd3) begin
                     riff_in = (tag_in == wps_pkg::TAG_RIFF);
                     tag_in = '0;
                  end
               end else if (cnt_ff >= 5'd8) begin
                  tag_in[8*cnt_ff[1:0] +: 8] = tag_ff[8*cnt_ff[1:0] +: 8] | req_data_byte;
               end
               cnt_in = cnt_ff + 5'd1;
               if (cnt_in >= 5'd12) begin
                  if (!riff_in) begin
                     main_v = 1'b1;
                     main_r = wps_pkg::error_result(wps_pkg::ERR_NO_RIFF);
                     phase_in = PH_ERR;
                  end else if (tag_in != wps_pkg::TAG_WAVE) begin
                     main_v = 1'b1;
                     main_r = wps_pkg::error_result(wps_pkg::ERR_NO_WAVE);
                     phase_in = PH_ERR;
                  end else begin
                     phase_in = PH_CHDR;
                     cnt_in = '0;
                     tag_in = '0;
                  end
               end
            end
            PH_CHDR: begin
               if (cnt_ff == 5'd0) begin
                  tag_in = '0;
                  len_in = '0;
               end
               if (cnt_ff < 5'd4) begin
                  tag_in[8*cnt_ff[1:0] +: 8] = tag_in[8*cnt_ff[1:0] +: 8] | req_data_byte;
               end else begin
                  len_in[8*cnt_ff[1:0] +: 8] = len_in[8*cnt_ff[1:0] +: 8] | req_data_byte;
               end
               cnt_in = cnt_ff + 5'd1;
               if (cnt_in >= 5'd8) begin
                  cnt_in = '0;
                  if (tag_in == wps_pkg::TAG_FMT) begin
                     if (len_in < wps_pkg::FMT_BODY_BYTES) begin
                        main_v = 1'b1;
                        main_r = wps_pkg::error_result(wps_pkg::ERR_FMT_SMALL);
                        phase_in = PH_ERR;
                     end else begin
                        fmt0_in = '0;
                        fmt1_in = '0;
                        phase_in = PH_FMT;
                     end
                  end else if (tag_in == wps_pkg::TAG_DATA) begin
                     if (!seen_ff) begin
                        main_v = 1'b1;
                        main_r = wps_pkg::error_result(wps_pkg::ERR_DATA_EARLY);
                        phase_in = PH_ERR;
                     end else if (fmt0_ff[15:0] != 16'd1) begin
                        main_v = 1'b1;
                        main_r = wps_pkg::error_result(wps_pkg::ERR_NOT_PCM);
                        phase_in = PH_ERR;
                     end else if (fmt0_ff[31:16] != 16'd1 && fmt0_ff[31:16] != 16'd2) begin
                        main_v = 1'b1;
                        main_r = wps_pkg::error_result(wps_pkg::ERR_CHANNELS);
                        phase_in = PH_ERR;
                     end else if (fmt1_ff[63:48] != 16'd16) begin
                        main_v = 1'b1;
                        main_r = wps_pkg::error_result(wps_pkg::ERR_DEPTH);
                        phase_in = PH_ERR;
                     end else if (fmt1_ff[47:32] == 16'd0) begin
                        main_v = 1'b1;
                        main_r = wps_pkg::error_result(wps_pkg::ERR_ALIGN);
                        phase_in = PH_ERR;
                     end else begin
                        div_req.start = 1'b1;
                        div_req.dividend = len_in;
                        phase_in = PH_DIV;
                        eofp_in = req_end_of_file;
                        eof_now = 1'b0;
                     end
                  end else begin
                     len_odd = {31'd0, len_in[0]};
                     skip_in = {1'b0, len_in} + {1'b0, len_odd};
                     phase_in = (skip_in == 33'd0) ? PH_CHDR : PH_SKIP;
                  end
               end
            end
            PH_FMT: begin
               if (cnt_ff[3]) begin
                  fmt1_in[8*cnt_ff[2:0] +: 8] = fmt1_ff[8*cnt_ff[2:0] +: 8] | req_data_byte;
               end else begin
                  fmt0_in[8*cnt_ff[2:0] +: 8] = fmt0_ff[8*cnt_ff[2:0] +: 8] | req_data_byte;
               end
               cnt_in = cnt_ff + 5'd1;
               if (cnt_in >= 5'd16) begin
                  seen_in = 1'b1;
                  cnt_in = '0;
                  skip_in = {1'b0, len_ff - wps_pkg::FMT_BODY_BYTES};
                  phase_in = (skip_in == 33'd0) ? PH_CHDR : PH_FSKIP;
               end
            end
            PH_FSKIP, PH_SKIP: begin
               if (skip_ff != 33'd0) begin
                  skip_in = skip_ff - 33'd1;
               end
               if (skip_in == 33'd0) begin
                  phase_in = PH_CHDR;
                  cnt_in = '0;
               end
            end
            PH_DATA: begin
               asm_in[8*cnt_ff[1:0] +: 8] = asm_ff[8*cnt_ff[1:0] +: 8] | req_data_byte;
               cnt_in = cnt_ff + 5'd1;
               if (cnt_in >= {2'd0, ch2, 1'b0}) begin
                  main_v = 1'b1;
                  main_r.result_kind = wps_pkg::KIND_FRAME;
                  main_r.left_sample = asm_in[15:0];
                  main_r.right_sample = (ch2 == 2'd2) ? asm_in[31:16] : 16'd0;
                  cnt_in = '0;
                  asm_in = '0;
                  frames_in = frames_ff - 32'd1;
                  if (frames_in == 32'd0) begin
                     main_r.last = 1'b1;
                     phase_in = PH_TAIL;
                  end
               end
            end
            default: begin
            end
         endcase
      end else if (phase_ff == PH_DIV && div_rsp.done) begin
         eof_now = eofp_ff;
         eofp_in = 1'b0;
         main_v = 1'b1;
         if (div_rsp.remainder != 16'd0) begin
            main_r = wps_pkg::error_result(wps_pkg::ERR_ALIGN);
            phase_in = PH_ERR;
         end else begin
            frames_in = div_rsp.quotient;
            main_r.result_kind = wps_pkg::KIND_FORMAT;
            main_r.channels = ch2;
            main_r.sample_rate = fmt0_ff[63:32];
            main_r.byte_rate = fmt1_ff[31:0];
            main_r.block_align = fmt1_ff[47:32];
            main_r.frame_count = div_rsp.quotient;
            cnt_in = '0;
            asm_in = '0;
            if (div_rsp.quotient == 32'd0) begin
               main_r.last = 1'b1;
               phase_in = PH_TAIL;
            end else begin
               phase_in = PH_DATA;
            end
         end
      end

      if (eof_now) begin
         unique case (phase_in)
            PH_HDR: begin
               eof_v = 1'b1;
               eof_r = wps_pkg::error_result(wps_pkg::ERR_SHORT_HEADER);
            end
            PH_CHDR, PH_FSKIP, PH_SKIP: begin
               eof_v = 1'b1;
               eof_r = wps_pkg::error_result(wps_pkg::ERR_MISSING);
            end
            PH_FMT: begin
               eof_v = 1'b1;
               eof_r = wps_pkg::error_result(wps_pkg::ERR_FMT_CUT);
            end
            PH_DATA: begin
               eof_v = 1'b1;
               eof_r = wps_pkg::error_result(wps_pkg::ERR_SAMPLES_CUT);
            end
            default: begin
            end
         endcase
         phase_in = PH_HDR;
         cnt_in = '0;
         tag_in = '0;
         len_in = '0;
         fmt0_in = '0;
         fmt1_in = '0;
         seen_in = 1'b0;
         frames_in = '0;
         asm_in = '0;
         riff_in = 1'b0;
         skip_in = '0;
      end
   end

   always_comb begin
      wr0 = main_v ? main_r : eof_r;
      wr1 = eof_r;
      n_push = {1'b0, main_v} + {1'b0, eof_v};
      count_in = count_ff + {1'b0, n_push} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR;
         cnt_ff <= '0;
         tag_ff <= '0;
         len_ff <= '0;
         fmt0_ff <= '0;
         fmt1_ff <= '0;
         seen_ff <= 1'b0;
         frames_ff <= '0;
         asm_ff <= '0;
         riff_ff <= 1'b0;
         skip_ff <= '0;
         eofp_ff <= 1'b0;
         count_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff <= cnt_in;
         tag_ff <= tag_in;
         len_ff <= len_in;
         fmt0_ff <= fmt0_in;
         fmt1_ff <= fmt1_in;
         seen_ff <= seen_in;
         frames_ff <= frames_in;
         asm_ff <= asm_in;
         riff_ff <= riff_in;
         skip_ff <= skip_in;
         eofp_ff <= eofp_in;
         count_ff <= count_in;
         head_ff <= head_ff + {1'b0, pop};
         tail_ff <= tail_ff + n_push;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         fifo_ff[tail_ff] <= wr0;
      end
      if (n_push == 2'd2) begin
         fifo_ff[tail_ff + 2'd1] <= wr1;
      end
   end

   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_result_kind = fifo_ff[head_ff].result_kind;
   assign rsp_left_sample = fifo_ff[head_ff].left_sample;
   assign rsp_right_sample = fifo_ff[head_ff].right_sample;
   assign rsp_channels = fifo_ff[head_ff].channels;
   assign rsp_sample_rate = fifo_ff[head_ff].sample_rate;
   assign rsp_byte_rate = fifo_ff[head_ff].byte_rate;
   assign rsp_block_align = fifo_ff[head_ff].block_align;
   assign rsp_frame_count = fifo_ff[head_ff].frame_count;
   assign rsp_error_code = fifo_ff[head_ff].error_code;
   assign rsp_last = fifo_ff[head_ff].last;

endmodule

[src/wps_checker.sv]
// Port-level checker for the WAV parser, bound to the top level.
module wps_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_result_kind,
   input logic [15:0] rsp_left_sample,
   input logic [15:0] rsp_right_sample,
   input logic [1:0]  rsp_channels,
   input logic [3:0]  rsp_error_code,
   input logic        rsp_last
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind))
      else $error("Stalled request changed.");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == wps_pkg::KIND_ERROR |->
         rsp_last && rsp_error_code <= wps_pkg::ERR_DATA_EARLY)
      else $error("Error request malformed.");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == wps_pkg::KIND_ERROR |->
         rsp_left_sample == 16'd0 && rsp_right_sample == 16'd0 && rsp_channels == 2'd0)
      else $error("Error request carries sample fields.");

   a_format_channels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == wps_pkg::KIND_FORMAT |->
         rsp_channels == 2'd1 || rsp_channels == 2'd2)
      else $error("Format request has a bad channel count.");

endmodule

bind wav_pcm16_stream_parser wps_checker u_wps_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_kind  (rsp_result_kind),
   .rsp_left_sample  (rsp_left_sample),
   .rsp_right_sample (rsp_right_sample),
   .rsp_channels     (rsp_channels),
   .rsp_error_code   (rsp_error_code),
   .rsp_last         (rsp_last)
);
